// ===== hdl/taylor_sine_cosine_tangent_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Taylor sine, cosine and tangent unit
// Shared helpers for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_COSINE_TANGENT_UNIT_DEFINES_SVH
`define TAYLOR_SINE_COSINE_TANGENT_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define TSCT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while the given disable term is high.
`define TSCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tsct_pkg.sv =====
// ----------------------------------------------------------------------------
// Taylor sine, cosine and tangent package
// Fixed-point constants, series coefficients and the records passed between
// the cells of the pipeline.
// ----------------------------------------------------------------------------
package tsct_pkg;

   localparam int FracBits   = 60;
   localparam int ValueWidth = 40;
   localparam int QuotWidth  = ValueWidth + 1;

   localparam logic [63:0] OneQ    = 64'h1000_0000_0000_0000;
   localparam logic [63:0] TauQ    = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] PiQ     = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] HalfPiQ = 64'h1921_FB54_442D_1847;

   localparam logic [63:0] ValPosMax = 64'h0000_007F_FFFF_FFFF;
   localparam logic [63:0] ValNegMag = 64'h0000_0080_0000_0000;
   localparam logic [QuotWidth-1:0] QuotCap = 41'h100_0000_0000;

   // 1/k! rounded to nearest with 60 fraction bits.
   localparam logic [63:0] CoefTab [16] = '{
      (OneQ + 64'd0) / 64'd1,
      (OneQ + 64'd0) / 64'd1,
      (OneQ + 64'd1) / 64'd2,
      (OneQ + 64'd3) / 64'd6,
      (OneQ + 64'd12) / 64'd24,
      (OneQ + 64'd60) / 64'd120,
      (OneQ + 64'd360) / 64'd720,
      (OneQ + 64'd2520) / 64'd5040,
      (OneQ + 64'd20160) / 64'd40320,
      (OneQ + 64'd181440) / 64'd362880,
      (OneQ + 64'd1814400) / 64'd3628800,
      (OneQ + 64'd19958400) / 64'd39916800,
      (OneQ + 64'd239500800) / 64'd479001600,
      (OneQ + 64'd3113510400) / 64'd6227020800,
      (OneQ + 64'd43589145600) / 64'd87178291200,
      (OneQ + 64'd653837184000) / 64'd1307674368000
   };

   typedef enum logic [1:0] {
      CMD_SINE    = 2'd0,
      CMD_COSINE  = 2'd1,
      CMD_TANGENT = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DOMAIN    = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_SQUARE = 2'd0,
      CELL_HORNER = 2'd1,
      CELL_FINAL  = 2'd2
   } cell_mode_type;

   // Record carried through the modulo-tau reduction.
   typedef struct packed {
      cmd_type     cmd;
      logic        sneg;
      logic [63:0] mag;
      logic [63:0] rem;
   } red_type;

   // Record carried through the series evaluation.
   typedef struct packed {
      cmd_type     cmd;
      logic        sneg;
      logic        cneg;
      logic [63:0] xs;
      logic [63:0] x2;
      logic [63:0] ps;
      logic [63:0] pc;
   } work_type;

   // Record carried through the tangent division.
   typedef struct packed {
      cmd_type              cmd;
      logic                 sneg;
      logic                 cneg;
      logic [63:0]          smag;
      logic [63:0]          cmag;
      logic [63:0]          rem;
      logic [QuotWidth-1:0] quot;
      logic                 big;
   } div_type;

   // Sign and magnitude of a result before it is packed into the value.
   typedef struct packed {
      logic        neg;
      logic [63:0] mag;
      logic        dom;
      logic        tan;
      logic        zero;
   } fmt_type;

   // Joins the four 32 x 32 partial products and keeps bits 60 upwards.
   function automatic logic [63:0] mul_fold(input logic [63:0] ll, input logic [63:0] lh,
                                            input logic [63:0] hl, input logic [63:0] hh);
      logic [127:0] sum;
      sum = {hh, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0};
      return sum[FracBits+63:FracBits];
   endfunction

endpackage

// ===== hdl/tsct_reduce_cell.sv =====
// ----------------------------------------------------------------------------
// Reduction cell
// One restoring step of the angle magnitude modulo tau: shift in one bit,
// subtract tau when the remainder reaches it.
// ----------------------------------------------------------------------------
module tsct_reduce_cell #(
   parameter bit ShiftOnly = 1'b0,
   parameter int BitIdx    = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tsct_pkg::red_type in_data,
   output logic              out_valid,
   output tsct_pkg::red_type out_data
);

   logic              valid_ff;
   tsct_pkg::red_type data_ff;
   tsct_pkg::red_type data_in;
   logic [63:0]       rem_sh;
   logic              new_bit;

   always_comb begin
      new_bit = ShiftOnly ? 1'b0 : in_data.mag[BitIdx[5:0]];
      // The remainder stays below tau, so the shift cannot overflow.
      rem_sh  = {in_data.rem[62:0], new_bit};
      data_in = in_data;
      if (rem_sh >= tsct_pkg::TauQ) begin
         data_in.rem = rem_sh - tsct_pkg::TauQ;
      end else begin
         data_in.rem = rem_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/tsct_trig_cell.sv =====
// ----------------------------------------------------------------------------
// Series cell
// Three-stage cell of the sine and cosine lanes: partial products, product
// assembly, then the Horner update (or the squaring or final step).
// ----------------------------------------------------------------------------
module tsct_trig_cell #(
   parameter tsct_pkg::cell_mode_type Mode = tsct_pkg::CELL_HORNER,
   parameter int KSine   = 1,
   parameter int KCos    = 2,
   parameter bit CosStep = 1'b1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tsct_pkg::work_type in_data,
   output logic               out_valid,
   output tsct_pkg::work_type out_data
);

   localparam logic [63:0] CoefS = tsct_pkg::CoefTab[KSine];
   localparam logic [63:0] CoefC = tsct_pkg::CoefTab[KCos];

   logic [63:0] sa;
   logic [63:0] sb;
   logic [63:0] pps_in [4];
   logic [63:0] ppc_in [4];
   logic [63:0] pps_ff [4];
   logic [63:0] ppc_ff [4];
   logic [63:0] ts_in;
   logic [63:0] tc_in;
   logic [63:0] ts_ff;
   logic [63:0] tc_ff;

   logic [2:0]         valid_ff;
   tsct_pkg::work_type w1_ff;
   tsct_pkg::work_type w2_ff;
   tsct_pkg::work_type w3_ff;
   tsct_pkg::work_type w3_in;

   always_comb begin
      case (Mode)
         tsct_pkg::CELL_SQUARE: begin
            sa = in_data.xs;
            sb = in_data.xs;
         end
         tsct_pkg::CELL_FINAL: begin
            sa = in_data.xs;
            sb = in_data.ps;
         end
         default: begin
            sa = in_data.x2;
            sb = in_data.ps;
         end
      endcase
      pps_in[0] = 64'(sa[31:0]) * 64'(sb[31:0]);
      pps_in[1] = 64'(sa[31:0]) * 64'(sb[63:32]);
      pps_in[2] = 64'(sa[63:32]) * 64'(sb[31:0]);
      pps_in[3] = 64'(sa[63:32]) * 64'(sb[63:32]);
      ppc_in[0] = 64'(in_data.x2[31:0]) * 64'(in_data.pc[31:0]);
      ppc_in[1] = 64'(in_data.x2[31:0]) * 64'(in_data.pc[63:32]);
      ppc_in[2] = 64'(in_data.x2[63:32]) * 64'(in_data.pc[31:0]);
      ppc_in[3] = 64'(in_data.x2[63:32]) * 64'(in_data.pc[63:32]);
   end

   always_comb begin
      ts_in = tsct_pkg::mul_fold(pps_ff[0], pps_ff[1], pps_ff[2], pps_ff[3]);
      tc_in = tsct_pkg::mul_fold(ppc_ff[0], ppc_ff[1], ppc_ff[2], ppc_ff[3]);
   end

   always_comb begin
      w3_in = w2_ff;
      case (Mode)
         tsct_pkg::CELL_SQUARE: begin
            w3_in.x2 = ts_ff;
            w3_in.ps = tsct_pkg::CoefTab[15];
            w3_in.pc = tsct_pkg::CoefTab[14];
         end
         tsct_pkg::CELL_HORNER: begin
            // Inner Horner steps are floored at zero.
            w3_in.ps = (ts_ff > CoefS) ? 64'd0 : CoefS - ts_ff;
            if (CosStep) begin
               w3_in.pc = (tc_ff > CoefC) ? 64'd0 : CoefC - tc_ff;
            end else begin
               w3_in.pc = tc_ff;
            end
         end
         tsct_pkg::CELL_FINAL: begin
            w3_in.ps = ts_ff;
            // The last cosine step is signed: one minus the tail.
            if (w2_ff.pc <= tsct_pkg::OneQ) begin
               w3_in.pc = tsct_pkg::OneQ - w2_ff.pc;
            end else begin
               w3_in.pc   = w2_ff.pc - tsct_pkg::OneQ;
               w3_in.cneg = !w2_ff.cneg;
            end
         end
         default: begin
            w3_in = w2_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pps_ff <= pps_in;
         ppc_ff <= ppc_in;
         w1_ff  <= in_data;
         ts_ff  <= ts_in;
         tc_ff  <= tc_in;
         w2_ff  <= w1_ff;
         w3_ff  <= w3_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = w3_ff;

endmodule

// ===== hdl/tsct_div_cell.sv =====
// ----------------------------------------------------------------------------
// Division cell
// One restoring step of the tangent quotient, with a sticky flag for a
// quotient that has passed the saturation cap.
// ----------------------------------------------------------------------------
module tsct_div_cell #(
   parameter bit HasBit = 1'b1,
   parameter int SrcIdx = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tsct_pkg::div_type in_data,
   output logic              out_valid,
   output tsct_pkg::div_type out_data
);

   logic                          valid_ff;
   tsct_pkg::div_type             data_ff;
   tsct_pkg::div_type             data_in;
   logic [64:0]                   rem_sh;
   logic [64:0]                   rem_sub;
   logic                          ge;
   logic [tsct_pkg::QuotWidth-1:0] quot_n;

   always_comb begin
      rem_sh  = {in_data.rem, HasBit ? in_data.smag[SrcIdx[5:0]] : 1'b0};
      rem_sub = rem_sh - {1'b0, in_data.cmag};
      ge      = rem_sh >= {1'b0, in_data.cmag};
      quot_n  = {in_data.quot[tsct_pkg::QuotWidth-2:0], ge};
      data_in = in_data;
      data_in.rem  = ge ? rem_sub[63:0] : rem_sh[63:0];
      data_in.quot = quot_n;
      // Once past the cap the quotient only grows, so the flag sticks.
      data_in.big  = in_data.big || in_data.quot[tsct_pkg::QuotWidth-1] ||
                     (quot_n > tsct_pkg::QuotCap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/taylor_sine_cosine_tangent_unit.sv =====
// ----------------------------------------------------------------------------
// Taylor sine, cosine and tangent unit
// Takes a command and a fixed-point angle in radians and returns the sine,
// cosine or tangent with a status code, one transfer in and one out per item.
//
// Usage: the request channel carries req_cmd and req_angle, the response
// channel rsp_value and rsp_status. A transfer happens when valid is high and
// stall is low. The unit is a straight pipeline of cells and, while req_stall
// is low, takes a new item in every cycle; each item delivers exactly one
// result, in order. From request transfer to response valid, an item passes
// one reduction cell per angle bit and per extra fraction bit, nine
// three-stage series cells, one division cell per quotient bit, and the input,
// folding and output stages.
// Reset clears every valid bit; nothing is in flight afterwards.
// When the receiver stalls, a finished result waits in the output register
// and the next one moves into a skid register; only with the skid register
// full does req_stall rise and the whole pipeline hold.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_tangent_unit #(
   parameter int ANGLE_WIDTH = 32,
   parameter int ANGLE_FRAC  = 26,
   parameter int RESULT_FRAC = 31
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_cmd,
   input  logic signed [ANGLE_WIDTH-1:0]          req_angle,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [tsct_pkg::ValueWidth-1:0] rsp_value,
   output logic [1:0]                             rsp_status
);

   localparam int RedSteps   = ANGLE_WIDTH + tsct_pkg::FracBits - ANGLE_FRAC;
   localparam int DivSteps   = 64 + RESULT_FRAC;
   localparam int TrigCells  = 9;
   localparam int RoundShift = tsct_pkg::FracBits - RESULT_FRAC;
   localparam logic [64:0] RoundHalf =
      (RoundShift > 0) ? (65'd1 << ((RoundShift > 0) ? RoundShift - 1 : 0)) : 65'd0;
   localparam int VW = tsct_pkg::ValueWidth;

   function automatic logic [63:0] round_mag(input logic [63:0] m);
      logic [64:0] s;
      s = (65'(m) + RoundHalf) >> RoundShift;
      return s[63:0];
   endfunction

   // Returns the saturation flag above the packed two's complement value.
   function automatic logic [VW:0] pack_value(input logic neg, input logic [63:0] mag);
      logic          sat;
      logic [63:0]   neg_mag;
      logic [VW-1:0] v;
      neg_mag = ~mag + 64'd1;
      if (neg) begin
         sat = mag > tsct_pkg::ValNegMag;
         v   = sat ? tsct_pkg::ValNegMag[VW-1:0] : neg_mag[VW-1:0];
      end else begin
         sat = mag > tsct_pkg::ValPosMax;
         v   = sat ? tsct_pkg::ValPosMax[VW-1:0] : mag[VW-1:0];
      end
      return {sat, v};
   endfunction

   logic adv;

   // Input stage
   logic [ANGLE_WIDTH-1:0] angle_mag;
   tsct_pkg::red_type      in_data_in;
   tsct_pkg::red_type      in_data_ff;
   logic                   in_valid_ff;

   logic              red_valid [RedSteps+1];
   tsct_pkg::red_type red_data  [RedSteps+1];

   // Folding stages
   tsct_pkg::work_type fold1_in;
   tsct_pkg::work_type fold1_ff;
   logic               fold1_valid_ff;
   tsct_pkg::work_type fold2_in;
   tsct_pkg::work_type fold2_ff;
   logic               fold2_valid_ff;

   logic               work_valid [TrigCells+1];
   tsct_pkg::work_type work_data  [TrigCells+1];

   logic              div_valid [DivSteps+1];
   tsct_pkg::div_type div_data  [DivSteps+1];

   // Output formatting
   logic [tsct_pkg::QuotWidth-1:0] quot_final;
   tsct_pkg::fmt_type              o1_in;
   tsct_pkg::fmt_type              o1_ff;
   logic                           o1_valid_ff;
   logic [VW:0]                    packed_res;
   logic [VW-1:0]                  fin_value;
   tsct_pkg::status_type           fin_status;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [VW-1:0]        rsp_value_ff;
   logic [VW-1:0]        rsp_value_in;
   tsct_pkg::status_type rsp_status_ff;
   tsct_pkg::status_type rsp_status_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   logic [VW-1:0]        skid_value_ff;
   logic [VW-1:0]        skid_value_in;
   tsct_pkg::status_type skid_status_ff;
   tsct_pkg::status_type skid_status_in;

   // The pipeline moves whenever the skid register is free.
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_comb begin
      angle_mag = req_angle[ANGLE_WIDTH-1] ? $unsigned(-req_angle) : $unsigned(req_angle);
      in_data_in.cmd  = tsct_pkg::cmd_type'(req_cmd);
      in_data_in.sneg = req_angle[ANGLE_WIDTH-1];
      in_data_in.mag  = 64'(angle_mag);
      in_data_in.rem  = 64'd0;
   end

   assign red_valid[0] = in_valid_ff;
   assign red_data[0]  = in_data_ff;

   for (genvar i = 0; i < RedSteps; i++) begin : g_red
      tsct_reduce_cell #(
         .ShiftOnly(i >= ANGLE_WIDTH),
         .BitIdx   ((i < ANGLE_WIDTH) ? ANGLE_WIDTH - 1 - i : 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (red_valid[i]),
         .in_data  (red_data[i]),
         .out_valid(red_valid[i+1]),
         .out_data (red_data[i+1])
      );
   end

   // Mirror into [0, pi], then into [0, pi/2], tracking the signs.
   always_comb begin
      fold1_in.cmd  = red_data[RedSteps].cmd;
      fold1_in.sneg = red_data[RedSteps].sneg;
      fold1_in.cneg = 1'b0;
      fold1_in.xs   = red_data[RedSteps].rem;
      fold1_in.x2   = 64'd0;
      fold1_in.ps   = 64'd0;
      fold1_in.pc   = 64'd0;
      if (red_data[RedSteps].rem > tsct_pkg::PiQ) begin
         fold1_in.xs   = tsct_pkg::TauQ - red_data[RedSteps].rem;
         fold1_in.sneg = !red_data[RedSteps].sneg;
      end
   end

   always_comb begin
      fold2_in = fold1_ff;
      if (fold1_ff.xs > tsct_pkg::HalfPiQ) begin
         fold2_in.xs   = tsct_pkg::PiQ - fold1_ff.xs;
         fold2_in.cneg = 1'b1;
      end
   end

   assign work_valid[0] = fold2_valid_ff;
   assign work_data[0]  = fold2_ff;

   for (genvar c = 0; c < TrigCells; c++) begin : g_trig
      tsct_trig_cell #(
         .Mode   ((c == 0) ? tsct_pkg::CELL_SQUARE :
                  (c == TrigCells - 1) ? tsct_pkg::CELL_FINAL : tsct_pkg::CELL_HORNER),
         .KSine  ((c >= 1 && c <= 7) ? 15 - 2 * c : 1),
         .KCos   ((c >= 1 && c <= 6) ? 14 - 2 * c : 2),
         .CosStep(c >= 1 && c <= 6)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (work_valid[c]),
         .in_data  (work_data[c]),
         .out_valid(work_valid[c+1]),
         .out_data (work_data[c+1])
      );
   end

   always_comb begin
      div_valid[0]     = work_valid[TrigCells];
      div_data[0].cmd  = work_data[TrigCells].cmd;
      div_data[0].sneg = work_data[TrigCells].sneg;
      div_data[0].cneg = work_data[TrigCells].cneg;
      div_data[0].smag = work_data[TrigCells].ps;
      div_data[0].cmag = work_data[TrigCells].pc;
      div_data[0].rem  = 64'd0;
      div_data[0].quot = '0;
      div_data[0].big  = 1'b0;
   end

   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      localparam int J = DivSteps - 1 - i;
      tsct_div_cell #(
         .HasBit(J >= RESULT_FRAC),
         .SrcIdx((J >= RESULT_FRAC) ? J - RESULT_FRAC : 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (adv),
         .in_valid (div_valid[i]),
         .in_data  (div_data[i]),
         .out_valid(div_valid[i+1]),
         .out_data (div_data[i+1])
      );
   end

   always_comb begin
      quot_final = div_data[DivSteps].big ? tsct_pkg::QuotCap : div_data[DivSteps].quot;
      o1_in = '0;
      case (div_data[DivSteps].cmd)
         tsct_pkg::CMD_SINE: begin
            o1_in.neg = div_data[DivSteps].sneg && (div_data[DivSteps].smag != 64'd0);
            o1_in.mag = round_mag(div_data[DivSteps].smag);
         end
         tsct_pkg::CMD_COSINE: begin
            o1_in.neg = div_data[DivSteps].cneg && (div_data[DivSteps].cmag != 64'd0);
            o1_in.mag = round_mag(div_data[DivSteps].cmag);
         end
         tsct_pkg::CMD_TANGENT: begin
            if (div_data[DivSteps].cmag == 64'd0) begin
               o1_in.zero = 1'b1;
               o1_in.dom  = 1'b1;
            end else begin
               o1_in.neg = (div_data[DivSteps].sneg != div_data[DivSteps].cneg) &&
                           (quot_final != '0);
               o1_in.mag = 64'(quot_final);
               o1_in.tan = 1'b1;
            end
         end
         default: begin
            o1_in.zero = 1'b1;
         end
      endcase
   end

   always_comb begin
      packed_res = pack_value(o1_ff.neg, o1_ff.mag);
      fin_value  = o1_ff.zero ? '0 : packed_res[VW-1:0];
      if (o1_ff.dom) begin
         fin_status = tsct_pkg::STATUS_DOMAIN;
      end else if (o1_ff.tan && packed_res[VW]) begin
         fin_status = tsct_pkg::STATUS_SATURATED;
      end else begin
         fin_status = tsct_pkg::STATUS_OK;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;
      skid_valid_in  = skid_valid_ff;
      skid_value_in  = skid_value_ff;
      skid_status_in = skid_status_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = skid_value_ff;
            rsp_status_in = skid_status_ff;
         end else begin
            rsp_valid_in  = o1_valid_ff;
            rsp_value_in  = fin_value;
            rsp_status_in = fin_status;
         end
         skid_valid_in = 1'b0;
      end else if (!skid_valid_ff) begin
         skid_valid_in  = o1_valid_ff;
         skid_value_in  = fin_value;
         skid_status_in = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         fold1_valid_ff <= 1'b0;
         fold2_valid_ff <= 1'b0;
         o1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         if (adv) begin
            in_valid_ff    <= req_valid;
            fold1_valid_ff <= red_valid[RedSteps];
            fold2_valid_ff <= fold1_valid_ff;
            o1_valid_ff    <= div_valid[DivSteps];
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_data_ff <= in_data_in;
         fold1_ff   <= fold1_in;
         fold2_ff   <= fold2_in;
         o1_ff      <= o1_in;
      end
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
      skid_value_ff  <= skid_value_in;
      skid_status_ff <= skid_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hdl/tsct_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the Taylor sine, cosine and tangent unit
// Watches the unit's ports and checks the empty state after reset, the status
// codes against the values and that req_stall is high only while rsp_valid is.
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_tangent_unit_defines.svh"

module tsct_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [tsct_pkg::ValueWidth-1:0] rsp_value,
   input logic [1:0]                             rsp_status
);

   `TSCT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall, "result after reset")
   `TSCT_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status <= tsct_pkg::STATUS_SATURATED, "unknown status")
   `TSCT_ASSERT_IMPLY(a_domain_zero, clock, reset, rsp_valid && rsp_status == tsct_pkg::STATUS_DOMAIN, rsp_value == '0, "domain status with a value")
   `TSCT_ASSERT_IMPLY(a_sat_extreme, clock, reset, rsp_valid && rsp_status == tsct_pkg::STATUS_SATURATED, rsp_value == tsct_pkg::ValPosMax[tsct_pkg::ValueWidth-1:0] || rsp_value == tsct_pkg::ValNegMag[tsct_pkg::ValueWidth-1:0], "saturation flagged off the limits")
   `TSCT_ASSERT_IMPLY(a_stall_held, clock, reset, req_stall, rsp_valid, "input stalled with no result waiting")

endmodule

bind taylor_sine_cosine_tangent_unit tsct_checker u_tsct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_value (rsp_value),
   .rsp_status(rsp_status)
);

// ===== test/tb_taylor_sine_cosine_tangent_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the Taylor sine, cosine and tangent unit
// Drives commands and angles through the request channel and checks every
// response transfer against a bit-exact predictor of the fixed-point series,
// with random gaps and stalls, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module tb_taylor_sine_cosine_tangent_unit;

   localparam int AngW  = 32;
   localparam int AngF  = 26;
   localparam int ResF  = 31;
   localparam int Latency = AngW + 60 - AngF + ResF + 96;
   localparam logic signed [AngW-1:0] HalfPiAngle = 32'sd105414357;

   typedef struct {
      logic [tsct_pkg::ValueWidth-1:0] value;
      logic [1:0]                      status;
   } trig_result_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic [1:0]                             req_cmd;
   logic signed [AngW-1:0]                 req_angle;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic signed [tsct_pkg::ValueWidth-1:0] rsp_value;
   logic [1:0]                             rsp_status;

   trig_result_type pending_results[$];
   int  error_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   bit  no_idle = 0;
   int  long_hold = 0;

   taylor_sine_cosine_tangent_unit #(
      .ANGLE_WIDTH(AngW), .ANGLE_FRAC(AngF), .RESULT_FRAC(ResF)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_angle(req_angle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Truncated product with 60 fraction bits.
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = a * b;
      return p[123:60];
   endfunction

   function automatic logic [63:0] inv_fact(input int k);
      logic [63:0] f;
      f = 1;
      for (int i = 2; i <= k; i++) f = f * i;
      return (tsct_pkg::OneQ + (f >> 1)) / f;
   endfunction

   function automatic logic [63:0] horner_step(input logic [63:0] c, input logic [63:0] x2,
                                               input logic [63:0] p);
      logic [63:0] t;
      t = qmul(x2, p);
      return (t > c) ? 64'd0 : c - t;
   endfunction

   function automatic logic [tsct_pkg::ValueWidth-1:0] to_value(input bit neg,
                                                                input logic [63:0] mag,
                                                                output bit sat);
      logic [63:0] m;
      m = mag;
      sat = 0;
      if (neg) begin
         if (m > tsct_pkg::ValNegMag) begin
            m = tsct_pkg::ValNegMag;
            sat = 1;
         end
         m = -m;
      end else if (m > tsct_pkg::ValPosMax) begin
         m = tsct_pkg::ValPosMax;
         sat = 1;
      end
      return m[tsct_pkg::ValueWidth-1:0];
   endfunction

   function automatic trig_result_type predict_trig(input logic [1:0] cmd,
                                                    input logic [AngW-1:0] angle);
      trig_result_type res;
      logic [63:0] mag, r, xs, xc, x2, p, smag, cmag, q, rm;
      logic [63:0] cap;
      bit sneg, cneg, sat;
      cap = 64'd1 << 40;
      res.value = '0;
      res.status = tsct_pkg::STATUS_OK;
      if (cmd == tsct_pkg::CMD_UNUSED) return res;
      sneg = angle[AngW-1];
      cneg = 0;
      mag = sneg ? 64'(-angle) : 64'(angle);
      mag = mag & ((64'd1 << AngW) - 1);
      r = 0;
      for (int i = AngW - 1; i >= 0; i--) begin
         r = (r << 1) | mag[i];
         if (r >= tsct_pkg::TauQ) r = r - tsct_pkg::TauQ;
      end
      for (int i = 0; i < 60 - AngF; i++) begin
         r = r << 1;
         if (r >= tsct_pkg::TauQ) r = r - tsct_pkg::TauQ;
      end
      xs = r;
      if (xs > tsct_pkg::PiQ) begin
         xs = tsct_pkg::TauQ - xs;
         sneg = !sneg;
      end
      if (xs > tsct_pkg::HalfPiQ) begin
         xs = tsct_pkg::PiQ - xs;
         cneg = 1;
      end
      xc = xs;
      x2 = qmul(xs, xs);
      p = inv_fact(15);
      for (int k = 13; k >= 1; k -= 2) p = horner_step(inv_fact(k), x2, p);
      smag = qmul(xs, p);
      x2 = qmul(xc, xc);
      p = inv_fact(14);
      for (int k = 12; k >= 2; k -= 2) p = horner_step(inv_fact(k), x2, p);
      p = qmul(x2, p);
      if (p <= tsct_pkg::OneQ) begin
         cmag = tsct_pkg::OneQ - p;
      end else begin
         cmag = p - tsct_pkg::OneQ;
         cneg = !cneg;
      end
      if (cmd == tsct_pkg::CMD_SINE) begin
         res.value = to_value(sneg && smag != 0, (smag + (64'd1 << 28)) >> 29, sat);
      end else if (cmd == tsct_pkg::CMD_COSINE) begin
         res.value = to_value(cneg && cmag != 0, (cmag + (64'd1 << 28)) >> 29, sat);
      end else if (cmag == 0) begin
         res.status = tsct_pkg::STATUS_DOMAIN;
      end else begin
         q = smag / cmag;
         rm = smag % cmag;
         if (q > cap) q = cap;
         for (int k = 0; k < ResF; k++) begin
            rm = rm << 1;
            q = q << 1;
            if (rm >= cmag) begin
               rm = rm - cmag;
               q = q | 64'd1;
            end
            if (q > cap) q = cap;
         end
         res.value = to_value((sneg != cneg) && q != 0, q, sat);
         res.status = sat ? tsct_pkg::STATUS_SATURATED : tsct_pkg::STATUS_OK;
      end
      return res;
   endfunction

   // Offers one item after a random gap and returns once it has been transferred.
   task automatic send_angle(input logic [1:0] cmd, input logic [AngW-1:0] angle);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_angle <= angle;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(predict_trig(cmd, angle));
      sent_count++;
   endtask

   task automatic finish_sending();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [1:0] random_cmd();
      int c;
      c = $urandom_range(0, 31);
      if (c == 0) return tsct_pkg::CMD_UNUSED;
      return 2'(c % 3);
   endfunction

   function automatic logic [AngW-1:0] random_angle();
      logic signed [AngW-1:0] a;
      case ($urandom_range(0, 3))
         0: a = $urandom;
         1: a = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
         2: a = HalfPiAngle * $signed($urandom_range(0, 40))
                + $signed($urandom_range(0, 64)) - 32;
         default: a = $urandom_range(0, 1 << 12);
      endcase
      if ($urandom_range(0, 1)) a = -a;
      return a;
   endfunction

   // Receiver: a random stall before each result, or a long hold-off on request.
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold > 0) begin
            n = long_hold;
            long_hold = 0;
         end else begin
            n = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Checks every response transfer against the oldest prediction.
   always @(posedge clock) begin
      trig_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no result expected");
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            checked_count++;
            if (rsp_value !== exp_res.value) begin
               $error("value: expected %h, actual %h", exp_res.value, rsp_value);
               error_count++;
            end
            if (rsp_status !== exp_res.status) begin
               $error("status: expected %0d, actual %0d", exp_res.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   task automatic test_edge_angles();
      logic [AngW-1:0] angles[14];
      angles = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 HalfPiAngle, -HalfPiAngle, HalfPiAngle + 1, HalfPiAngle - 1,
                 HalfPiAngle * 2, HalfPiAngle * 3, HalfPiAngle * 4, 32'h0400_0000,
                 32'hAAAA_5555};
      for (int i = 0; i < 14; i++) begin
         send_angle(tsct_pkg::CMD_TANGENT, angles[i]);
         if (i % 2 == 0) send_angle(tsct_pkg::CMD_SINE, angles[i]);
         else send_angle(tsct_pkg::CMD_COSINE, angles[i]);
      end
      send_angle(tsct_pkg::CMD_UNUSED, 32'h1234_5678);
   endtask

   task automatic test_random_stream(input int count);
      for (int i = 0; i < count; i++) begin
         // Every so often a run with no gaps or stalls on either side.
         if (i % 200 == 100) no_idle = 1;
         if (i % 200 == 140) no_idle = 0;
         send_angle(random_cmd(), random_angle());
      end
      no_idle = 0;
   endtask

   // The receiver holds off while items keep coming, so the pipeline fills.
   task automatic test_backpressure();
      long_hold = 2 * Latency + 100;
      no_idle = 1;
      for (int i = 0; i < Latency + 60; i++) send_angle(random_cmd(), random_angle());
      no_idle = 0;
   endtask

   task automatic test_drain_and_resume();
      finish_sending();
      wait_drained();
      for (int i = 0; i < 20; i++) send_angle(random_cmd(), random_angle());
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = tsct_pkg::CMD_SINE;
      req_angle = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_angles();
      test_drain_and_resume();
      test_backpressure();
      test_random_stream(1200);
      finish_sending();
      wait_drained();
      repeat (Latency + 20) @(posedge clock);
      $display("Sent %0d items (all commands, edge, random and near-quadrant angles),",
               sent_count);
      $display("checked %0d results under random gaps, stalls and a long hold-off.",
               checked_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[taylor_sine_cosine_tangent_unit] OK");
      end else begin
         $display("[taylor_sine_cosine_tangent_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[taylor_sine_cosine_tangent_unit] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tsct_pkg.sv
hdl/tsct_reduce_cell.sv
hdl/tsct_trig_cell.sv
hdl/tsct_div_cell.sv
hdl/taylor_sine_cosine_tangent_unit.sv
hdl/tsct_checker.sv
test/tb_taylor_sine_cosine_tangent_unit.sv
